[rtl/fip_frame_parser_core_defines.svh]
// Assertion macros shared by the FIP parser checkers.
`ifndef FIP_FRAME_PARSER_CORE_DEFINES_SVH
`define FIP_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FIP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fip: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FIP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fip: next-cycle check failed");

`endif

[rtl/fip_pkg.sv]
// Types, constants and the descriptor field table of the FIP frame parser.
`timescale 1ns / 1ps
package fip_pkg;

	localparam int HDR_LEN  = 10;
	localparam int WORD_SHIFT = 2;   // 4-byte words

	localparam logic [1:0] KIND_HDR  = 2'd0;
	localparam logic [1:0] KIND_DESC = 2'd1;
	localparam logic [1:0] KIND_STAT = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_HDR_SHORT = 3'd1;
	localparam logic [2:0] ST_ZERO_LEN  = 3'd2;
	localparam logic [2:0] ST_OVER_LIST = 3'd3;
	localparam logic [2:0] ST_TRUNC     = 3'd4;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DESC   = 2'd1,
		PH_STOP   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} in_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [15:0] opcode;
		logic [7:0]  subcode;
		logic [15:0] header_flags;
		logic [15:0] list_words;
		logic [7:0]  desc_code;
		logic [7:0]  desc_words;
		logic [63:0] main_value;
		logic [47:0] aux_wide;
		logic [23:0] aux_narrow;
		logic [2:0]  end_status;
		logic        last_record;
	} out_t;

	// Records caused by one byte: an optional header/descriptor record,
	// then an optional end-of-frame status.
	typedef struct packed {
		logic       push;
		logic       has_rec;
		out_t       rec;
		logic       has_stat;
		logic [2:0] stat;
	} bndl_t;

	// Byte span of a field inside a descriptor: start offset and byte count.
	typedef struct packed {
		logic [5:0] s;
		logic [3:0] n;
	} fspan_t;

	typedef struct packed {
		fspan_t main_f;
		fspan_t aux_f;
		fspan_t nar_f;
	} fmap_t;

	function automatic fmap_t fip_field_map(input logic [3:0] t);
		fmap_t m;
		m = '0;
		unique case (t)
			4'd1:  m.main_f = '{6'd3, 4'd1};
			4'd2:  m.main_f = '{6'd2, 4'd6};
			4'd3:  m.nar_f  = '{6'd5, 4'd3};
			4'd4:  m.main_f = '{6'd4, 4'd8};
			4'd5: begin
				m.main_f = '{6'd8, 4'd8};
				m.aux_f  = '{6'd2, 4'd2};
				m.nar_f  = '{6'd5, 4'd3};
			end
			4'd6:  m.main_f = '{6'd2, 4'd2};
			4'd11: begin
				m.main_f = '{6'd12, 4'd8};
				m.aux_f  = '{6'd2, 4'd6};
				m.nar_f  = '{6'd9, 4'd3};
			end
			4'd12: m.main_f = '{6'd4, 4'd4};
			4'd13: m.main_f = '{6'd4, 4'd8};
			4'd14: m.main_f = '{6'd2, 4'd2};
			4'd15: begin
				m.main_f = '{6'd4, 4'd8};
				m.aux_f  = '{6'd40, 4'd4};
			end
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

[rtl/fip_parse.sv]
// Byte-wise header and descriptor parser: parse state and record build.
`timescale 1ns / 1ps
module fip_parse
	import fip_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  in_t   din,
	output bndl_t bndl
);

	localparam logic [3:0] HDR_LAST = 4'(HDR_LEN - 1);

	phase_t      phase_q, phase_d;
	logic [3:0]  hdr_cnt_q, hdr_cnt_d;
	logic [15:0] opcode_q, opcode_d;
	logic [7:0]  subcode_q, subcode_d;
	logic [15:0] flags_q, flags_d;
	logic [3:0]  version_q, version_d;
	logic [17:0] list_left_q, list_left_d;
	logic [9:0]  desc_cnt_q, desc_cnt_d;
	logic [15:0] dhdr_q, dhdr_d;
	logic [63:0] main_q, main_d, main_put;
	logic [47:0] aux_q, aux_d, aux_put;
	logic [23:0] nar_q, nar_d, nar_put;
	logic [2:0]  status_q, status_d;

	logic [7:0]  b;
	logic        fr_end;
	fmap_t       fmap;
	logic        known_type;
	logic [7:0]  sel_m, sel_a, sel_n;
	logic [9:0]  dlen_cur, dlen_new;
	logic        hdr_rec, desc_rec;
	logic [2:0]  stat_code;

	// One-hot byte lane (LSB lane 0) that the byte at offset off lands in.
	function automatic logic [7:0] lane_sel(input fspan_t f, input logic [9:0] off);
		logic [10:0] last;
		logic [10:0] pos;
		lane_sel = '0;
		last = 11'(f.s) + 11'(f.n) - 11'd1;
		pos  = last - {1'b0, off};
		if (f.n != 4'd0 && {1'b0, off} >= 11'(f.s) && {1'b0, off} <= last) begin
			lane_sel[pos[2:0]] = 1'b1;
		end
	endfunction

	assign b      = din.frame_byte;
	assign fr_end = din.frame_end;

	assign fmap       = fip_field_map(dhdr_q[11:8]);
	assign known_type = (dhdr_q[15:12] == 4'd0);
	assign sel_m      = lane_sel(fmap.main_f, desc_cnt_q);
	assign sel_a      = lane_sel(fmap.aux_f, desc_cnt_q);
	assign sel_n      = lane_sel(fmap.nar_f, desc_cnt_q);
	assign dlen_cur   = {dhdr_q[7:0], 2'b00};
	assign dlen_new   = {b, 2'b00};

	always_comb begin
		main_put = main_q;
		aux_put  = aux_q;
		nar_put  = nar_q;
		for (int k = 0; k < 8; k++) begin
			if (known_type && sel_m[k]) begin
				main_put[8*k +: 8] = main_q[8*k +: 8] | b;
			end
		end
		for (int k = 0; k < 6; k++) begin
			if (known_type && sel_a[k]) begin
				aux_put[8*k +: 8] = aux_q[8*k +: 8] | b;
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (known_type && sel_n[k]) begin
				nar_put[8*k +: 8] = nar_q[8*k +: 8] | b;
			end
		end
	end

	always_comb begin
		phase_d     = phase_q;
		hdr_cnt_d   = hdr_cnt_q;
		opcode_d    = opcode_q;
		subcode_d   = subcode_q;
		flags_d     = flags_q;
		version_d   = version_q;
		list_left_d = list_left_q;
		desc_cnt_d  = desc_cnt_q;
		dhdr_d      = dhdr_q;
		main_d      = main_q;
		aux_d       = aux_q;
		nar_d       = nar_q;
		status_d    = status_q;
		hdr_rec     = 1'b0;
		desc_rec    = 1'b0;
		stat_code   = ST_OK;
		bndl        = '0;

		unique case (phase_q)
			PH_HEADER: begin
				case (hdr_cnt_q)
					4'd0: version_d = b[7:4];
					4'd2: opcode_d = {b, 8'h00};
					4'd3: opcode_d = {opcode_q[15:8], b};
					4'd5: subcode_d = b;
					4'd6: list_left_d = {b, 10'd0};
					4'd7: list_left_d = list_left_q | {8'd0, b, 2'b00};
					4'd8: flags_d = {b, 8'h00};
					4'd9: flags_d = {flags_q[15:8], b};
					default: ;
				endcase
				hdr_cnt_d = hdr_cnt_q + 4'd1;
				if (hdr_cnt_q == HDR_LAST) begin
					hdr_rec    = 1'b1;
					hdr_cnt_d  = '0;
					desc_cnt_d = '0;
					main_d     = '0;
					aux_d      = '0;
					nar_d      = '0;
					if (list_left_d == '0) begin
						phase_d  = PH_STOP;
						status_d = ST_OK;
					end else begin
						phase_d = PH_DESC;
					end
				end
			end
			PH_DESC: begin
				if (desc_cnt_q == 10'd0) begin
					dhdr_d     = {b, 8'h00};
					desc_cnt_d = 10'd1;
				end else if (desc_cnt_q == 10'd1) begin
					dhdr_d = {dhdr_q[15:8], b};
					if (b == 8'd0) begin
						phase_d  = PH_STOP;
						status_d = ST_ZERO_LEN;
					end else if ({8'd0, dlen_new} > list_left_q) begin
						phase_d  = PH_STOP;
						status_d = ST_OVER_LIST;
					end else begin
						desc_cnt_d = 10'd2;
					end
				end else begin
					main_d     = main_put;
					aux_d      = aux_put;
					nar_d      = nar_put;
					desc_cnt_d = desc_cnt_q + 10'd1;
					if ({1'b0, desc_cnt_q} + 11'd1 >= {1'b0, dlen_cur}) begin
						desc_rec    = 1'b1;
						list_left_d = list_left_q - {8'd0, dlen_cur};
						desc_cnt_d  = '0;
						main_d      = '0;
						aux_d       = '0;
						nar_d       = '0;
						if (list_left_d == '0) begin
							phase_d  = PH_STOP;
							status_d = ST_OK;
						end
					end
				end
			end
			default: ;   // stopped: bytes ignored until frame end
		endcase

		// record content, from the values after this byte
		bndl.has_rec = hdr_rec | desc_rec;
		if (hdr_rec) begin
			bndl.rec.record_kind  = KIND_HDR;
			bndl.rec.opcode       = opcode_d;
			bndl.rec.subcode      = subcode_d;
			bndl.rec.header_flags = flags_d;
			bndl.rec.list_words   = list_left_d[17:WORD_SHIFT];
			bndl.rec.aux_narrow   = {20'd0, version_d};
		end else begin
			bndl.rec.record_kind  = KIND_DESC;
			bndl.rec.desc_code    = dhdr_q[15:8];
			bndl.rec.desc_words   = dhdr_q[7:0];
			bndl.rec.main_value   = main_put;
			bndl.rec.aux_wide     = aux_put;
			bndl.rec.aux_narrow   = nar_put;
		end
		bndl.rec.last_record = ~fr_end;

		if (fr_end) begin
			unique case (phase_d)
				PH_HEADER: stat_code = ST_HDR_SHORT;
				PH_DESC:   stat_code = ST_TRUNC;
				default:   stat_code = status_d;
			endcase
			phase_d     = PH_HEADER;
			hdr_cnt_d   = '0;
			opcode_d    = '0;
			subcode_d   = '0;
			flags_d     = '0;
			version_d   = '0;
			list_left_d = '0;
			desc_cnt_d  = '0;
			dhdr_d      = '0;
			main_d      = '0;
			aux_d       = '0;
			nar_d       = '0;
			status_d    = '0;
		end
		bndl.has_stat = fr_end;
		bndl.stat     = stat_code;
		bndl.push     = accept & (hdr_rec | desc_rec | fr_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_cnt_q   <= '0;
			opcode_q    <= '0;
			subcode_q   <= '0;
			flags_q     <= '0;
			version_q   <= '0;
			list_left_q <= '0;
			desc_cnt_q  <= '0;
			dhdr_q      <= '0;
			main_q      <= '0;
			aux_q       <= '0;
			nar_q       <= '0;
			status_q    <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			hdr_cnt_q   <= hdr_cnt_d;
			opcode_q    <= opcode_d;
			subcode_q   <= subcode_d;
			flags_q     <= flags_d;
			version_q   <= version_d;
			list_left_q <= list_left_d;
			desc_cnt_q  <= desc_cnt_d;
			dhdr_q      <= dhdr_d;
			main_q      <= main_d;
			aux_q       <= aux_d;
			nar_q       <= nar_d;
			status_q    <= status_d;
		end
	end

endmodule

[rtl/fip_outq.sv]
// Two-entry record queue; splits a two-record bundle into two transfers.
`timescale 1ns / 1ps
module fip_outq
	import fip_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  bndl_t bndl,
	output logic  full,
	output logic  rec_valid,
	input  logic  rec_stall,
	output out_t  rec_data
);

	localparam int DEPTH = 2;

	bndl_t       ent_q [DEPTH];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        half_q;

	bndl_t       head;
	logic        show_rec;
	logic        xfer, pop;
	out_t        stat_rec;

	assign head     = ent_q[rd_q];
	assign show_rec = head.has_rec & ~half_q;
	assign full     = (cnt_q == 2'(DEPTH));

	assign rec_valid = (cnt_q != 2'd0);
	assign xfer      = rec_valid & ~rec_stall;
	assign pop       = xfer & ~(show_rec & head.has_stat);

	always_comb begin
		stat_rec             = '0;
		stat_rec.record_kind = KIND_STAT;
		stat_rec.end_status  = head.stat;
		stat_rec.last_record = 1'b1;
		rec_data             = show_rec ? head.rec : stat_rec;
	end

	always_ff @(posedge clk) begin
		if (bndl.push) begin
			ent_q[wr_q] <= bndl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			cnt_q  <= '0;
			half_q <= 1'b0;
		end else begin
			if (bndl.push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q   <= ~rd_q;
				half_q <= 1'b0;
			end else if (xfer) begin
				half_q <= 1'b1;
			end
			cnt_q <= cnt_q + {1'b0, bndl.push} - {1'b0, pop};
		end
	end

endmodule

[rtl/fip_frame_parser_core.sv]
// FIP frame parser: top level.
// Usage:
//  - Input channel byte_*: one frame byte per transfer, network order;
//    frame_end marks the frame's last byte.
//  - Output channel rec_*: one record per transfer: header record after the
//    10th header byte, one descriptor record per complete descriptor, and an
//    end-of-frame status record after the frame_end byte.
//  - Latency: a byte's first record is offered the cycle after its transfer
//    when the queue is empty.
//  - Throughput: one byte per cycle. A byte that causes two records (last
//    header byte, or last byte of a descriptor, that is also frame_end) holds
//    the output for two record transfers; with bytes back to back this fills
//    the queue and byte_stall is high for one cycle.
//  - byte_stall comes straight from the queue fill flag, so it never depends
//    combinationally on rec_stall.
//  - When the receiver stalls, the record on rec_data holds; bytes keep
//    flowing until both queue entries are taken.
//  - Reset clears the parse state to the start of a frame header and
//    empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps
module fip_frame_parser_core
	import fip_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic byte_valid,
	output logic byte_stall,
	input  in_t  byte_data,
	output logic rec_valid,
	input  logic rec_stall,
	output out_t rec_data
);

	logic  accept;
	bndl_t bndl;
	logic  q_full;

	// byte transfer
	assign accept     = byte_valid & ~q_full;
	assign byte_stall = q_full;

	// parse state registers and record build
	fip_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.din    (byte_data),
		.bndl   (bndl)
	);

	// record queue; its head entry drives the record output
	fip_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.bndl      (bndl),
		.full      (q_full),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_data  (rec_data)
	);

endmodule

[rtl/fip_chk.sv]
// Port-level checker for the FIP frame parser, bound to the top level.
`timescale 1ns / 1ps
`include "fip_frame_parser_core_defines.svh"
module fip_chk
	import fip_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	input logic byte_stall,
	input in_t  byte_data,
	input logic rec_valid,
	input logic rec_stall,
	input out_t rec_data
);

	// stalled record holds
	`FIP_ASSERT_NXT(a_rec_hold, rec_valid && rec_stall, rec_valid && $stable(rec_data))
	// the status record always closes a byte's records
	`FIP_ASSERT_IMP(a_stat_last, rec_valid && rec_data.record_kind == KIND_STAT, rec_data.last_record)
	// input only backs up behind pending records
	`FIP_ASSERT_IMP(a_stall_pend, byte_stall, rec_valid)
	// a frame end always yields a record on the next cycle
	`FIP_ASSERT_NXT(a_end_rec, byte_valid && !byte_stall && byte_data.frame_end, rec_valid)

endmodule

bind fip_frame_parser_core fip_chk u_fip_chk (.*);
